/* hdl/slr_pkg.sv */
// Shared constants and controller/datapath command types for the shuffled LCG generator.
// No dependencies; every other file in hdl/ refers to it by scoped names.
package slr_pkg;

  localparam int WORD_W = 31;
  localparam int MUL_W = 15;
  localparam int PROD_W = WORD_W + MUL_W;
  localparam logic [MUL_W-1:0] LCG_MUL = 15'd16807;
  localparam logic [WORD_W-1:0] LCG_MOD = 31'h7FFF_FFFF;
  localparam int WARM_EXTRA = 8;
  localparam int IDX_SHIFT = 40;
  localparam int RECIP_W = 16;
  localparam int QUOT_W = 7;

  typedef struct packed {
    logic load_seed;
    logic use_seed;
    logic lcg_mul;
    logic warm_red;
    logic draw_rd;
    logic draw_red;
    logic idx_mul;
    logic idx_fix;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic inited;
    logic cnt_zero;
  } dp_stat_t;

endpackage

/* hdl/slr_datapath.sv */
// Datapath: LCG multiply and Mersenne reduction, shuffle table, index divider, output register.
// Depends on slr_pkg; driven by slr_ctrl through slr_pkg::dp_cmd_t.
module slr_datapath #(
  parameter int TABLE_SIZE = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  slr_pkg::dp_cmd_t              cmd,
  output slr_pkg::dp_stat_t             stat,
  input  logic [slr_pkg::WORD_W-1:0]    seed_value,
  output logic [slr_pkg::WORD_W-1:0]    random_value
);

  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam int CNT_W = $clog2(TABLE_SIZE + slr_pkg::WARM_EXTRA);
  localparam longint BUCKET = 1 + 64'd2147483646 / TABLE_SIZE;
  localparam longint RECIP = (64'd1 << slr_pkg::IDX_SHIFT) / BUCKET;
  localparam logic [slr_pkg::WORD_W-1:0] BUCKET_V = slr_pkg::WORD_W'(BUCKET);
  localparam logic [slr_pkg::RECIP_W-1:0] RECIP_V = slr_pkg::RECIP_W'(RECIP);
  localparam int DIV_W = slr_pkg::WORD_W + slr_pkg::RECIP_W;

  logic [slr_pkg::WORD_W-1:0] x_r;
  logic [slr_pkg::WORD_W-1:0] last_r;
  logic [slr_pkg::WORD_W-1:0] rd_r;
  logic [slr_pkg::WORD_W-1:0] out_r;
  logic [slr_pkg::PROD_W-1:0] mul_r;
  logic [DIV_W-1:0]           prod_r;
  logic [IDX_W-1:0]           idx_r;
  logic [CNT_W-1:0]           cnt_r;
  logic [slr_pkg::WORD_W-1:0] tbl_mem [TABLE_SIZE];

  logic [slr_pkg::WORD_W-1:0] seed_fix;
  logic [slr_pkg::WORD_W:0]   red_sum;
  logic [slr_pkg::WORD_W-1:0] red_val;
  logic [slr_pkg::QUOT_W-1:0] q_est;
  logic [slr_pkg::WORD_W:0]   q_prod;
  logic [slr_pkg::WORD_W:0]   q_rem;
  logic [slr_pkg::QUOT_W-1:0] q_fix;
  logic [IDX_W-1:0]           idx_nxt;
  logic                       wr_en;
  logic [IDX_W-1:0]           wr_addr;

  always_comb begin
    if (seed_value == '0 || seed_value == slr_pkg::LCG_MOD) begin
      seed_fix = slr_pkg::WORD_W'(1);
    end else begin
      seed_fix = seed_value;
    end
  end

  always_comb begin
    red_sum = {1'b0, mul_r[slr_pkg::WORD_W-1:0]}
            + (slr_pkg::WORD_W + 1)'(mul_r[slr_pkg::PROD_W-1:slr_pkg::WORD_W]);
    if (red_sum >= {1'b0, slr_pkg::LCG_MOD}) begin
      red_val = slr_pkg::WORD_W'(red_sum - {1'b0, slr_pkg::LCG_MOD});
    end else begin
      red_val = red_sum[slr_pkg::WORD_W-1:0];
    end
  end

  always_comb begin
    q_est  = prod_r[slr_pkg::IDX_SHIFT +: slr_pkg::QUOT_W];
    q_prod = (slr_pkg::WORD_W + 1)'(q_est) * (slr_pkg::WORD_W + 1)'(BUCKET_V);
    q_rem  = {1'b0, last_r} - q_prod;
    if (q_rem >= {1'b0, BUCKET_V}) begin
      q_fix = q_est + slr_pkg::QUOT_W'(1);
    end else begin
      q_fix = q_est;
    end
    if (q_fix > slr_pkg::QUOT_W'(TABLE_SIZE - 1)) begin
      idx_nxt = IDX_W'(TABLE_SIZE - 1);
    end else begin
      idx_nxt = q_fix[IDX_W-1:0];
    end
  end

  always_comb begin
    wr_en   = cmd.draw_red || (cmd.warm_red && cnt_r < CNT_W'(TABLE_SIZE));
    wr_addr = cmd.draw_red ? idx_r : cnt_r[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tbl_mem[wr_addr] <= red_val;
    end
    if (cmd.draw_rd) begin
      rd_r <= tbl_mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r    <= slr_pkg::WORD_W'(1);
      last_r <= '0;
    end else begin
      if (cmd.load_seed) begin
        x_r <= cmd.use_seed ? seed_fix : slr_pkg::WORD_W'(1);
      end else if (cmd.warm_red || cmd.draw_red) begin
        x_r <= red_val;
      end
      if (cmd.warm_red && cnt_r == '0) begin
        last_r <= red_val;
      end else if (cmd.emit) begin
        last_r <= rd_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_seed) begin
      cnt_r <= CNT_W'(TABLE_SIZE + slr_pkg::WARM_EXTRA - 1);
    end else if (cmd.warm_red && cnt_r != '0) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
    if (cmd.lcg_mul) begin
      mul_r <= slr_pkg::PROD_W'(x_r) * slr_pkg::PROD_W'(slr_pkg::LCG_MUL);
    end
    if (cmd.idx_mul) begin
      prod_r <= DIV_W'(last_r) * DIV_W'(RECIP_V);
    end
    if (cmd.idx_fix) begin
      idx_r <= idx_nxt;
    end
    if (cmd.emit) begin
      out_r <= rd_r;
    end
  end

  assign stat.inited   = (last_r != '0);
  assign stat.cnt_zero = (cnt_r == '0);
  assign random_value  = out_r;

endmodule

/* hdl/slr_ctrl.sv */
// Controller: sequences seeding, warm-up, index division and each draw; owns the handshakes.
// Depends on slr_pkg; commands slr_datapath through slr_pkg::dp_cmd_t.
module slr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_opcode,
  output logic              out_valid,
  input  logic              out_ready,
  input  slr_pkg::dp_stat_t stat,
  output slr_pkg::dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    IDLE,
    WARM_MUL,
    WARM_RED,
    IDX_MUL,
    IDX_FIX,
    STEP_MUL,
    STEP_RED,
    EMIT
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   draw_pend_r;
  logic   emit_ok;
  logic   reseed;

  assign in_ready  = (state_r == IDLE);
  assign out_valid = out_valid_r;
  assign emit_ok   = (state_r == EMIT) && (!out_valid_r || out_ready);
  assign reseed    = in_opcode || !stat.inited;

  always_comb begin
    cmd = '0;
    unique case (state_r)
      IDLE: begin
        cmd.load_seed = in_valid && reseed;
        cmd.use_seed  = in_opcode;
      end
      WARM_MUL: cmd.lcg_mul = 1'b1;
      WARM_RED: cmd.warm_red = 1'b1;
      IDX_MUL:  cmd.idx_mul = 1'b1;
      IDX_FIX:  cmd.idx_fix = 1'b1;
      STEP_MUL: begin
        cmd.lcg_mul = 1'b1;
        cmd.draw_rd = 1'b1;
      end
      STEP_RED: cmd.draw_red = 1'b1;
      EMIT:     cmd.emit = emit_ok;
      default:  cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      out_valid_r <= 1'b0;
      draw_pend_r <= 1'b0;
    end else begin
      if (emit_ok) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        IDLE: begin
          if (in_valid) begin
            draw_pend_r <= 1'b1;
            state_r     <= reseed ? WARM_MUL : STEP_MUL;
          end
        end
        WARM_MUL: state_r <= WARM_RED;
        WARM_RED: state_r <= stat.cnt_zero ? IDX_MUL : WARM_MUL;
        IDX_MUL:  state_r <= IDX_FIX;
        IDX_FIX:  state_r <= draw_pend_r ? STEP_MUL : IDLE;
        STEP_MUL: state_r <= STEP_RED;
        STEP_RED: state_r <= EMIT;
        EMIT: begin
          if (emit_ok) begin
            draw_pend_r <= 1'b0;
            state_r     <= IDX_MUL;
          end
        end
        default:  state_r <= IDLE;
      endcase
    end
  end

endmodule

/* hdl/shuffled_lcg_random.sv */
// Shuffled multiplicative congruential random generator, top level.
// Depends on slr_pkg, slr_ctrl and slr_datapath.
//
// Input beat: in_opcode 0 draws the next value, 1 reseeds from in_seed_value (0 or
// 2^31-1 act as 1) and then draws. Each input beat yields exactly one output beat on
// out_random_value, a value in 1 .. 2^31-2; the uniform fraction is value / (2^31-1).
// A draw runs the generator multiply and reduce, emits its result to the output register,
// then runs the divider that picks the next table entry; the block takes no new beat
// until it is back in idle. A reseed adds a warm-up, which fills the shuffle table, and
// a run of the divider in front of the draw. The generator step is a multiply then a
// reduce, run once per draw and once per warm-up step; the divider is a multiply then a correct.
// After reset the block is unseeded; the first beat always seeds, with 1 for a draw.
// If the receiver stalls, the result holds in the output register; the block still
// takes one more input beat and works on it, then waits to deliver until the register
// is free.
module shuffled_lcg_random #(
  parameter int TABLE_SIZE = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_opcode,
  input  logic [slr_pkg::WORD_W-1:0] in_seed_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [slr_pkg::WORD_W-1:0] out_random_value
);

  slr_pkg::dp_cmd_t  cmd;
  slr_pkg::dp_stat_t stat;

  slr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_opcode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  slr_datapath #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .seed_value   (in_seed_value),
    .random_value (out_random_value)
  );

endmodule

/* hdl/slr_checker.sv */
// Port-level checker for shuffled_lcg_random, attached by the bind at the end.
// Depends on slr_pkg for the word width and modulus.
module slr_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [slr_pkg::WORD_W-1:0] out_random_value
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_random_value))
    else $error("output payload changed while stalled");

  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after a beat");

  a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_random_value != '0 && out_random_value != slr_pkg::LCG_MOD)
    else $error("output value outside the generator range");

endmodule

bind shuffled_lcg_random slr_checker u_slr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_random_value (out_random_value)
);
